// File: src/ppe_pkg.sv
// Shared types and constants of the polyline primitive expander.
// Used by every module of the block; depends on nothing.
package ppe_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int COLOR_WIDTH         = 32;
   localparam int MODE_WIDTH          = 3;
   localparam int FACTOR_WIDTH        = 16;
   localparam int COUNT_WIDTH         = 3;
   localparam int ADDR_WIDTH          = 5;
   localparam int DATA_WIDTH          = 32;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [MODE_WIDTH-1:0] MODE_LINES   = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_FILL    = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POINTS  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_SPECIAL = 3'd3;

   localparam logic [2:0] REG_DRAW_MODE = 3'd0;
   localparam logic [2:0] REG_POS_X     = 3'd1;
   localparam logic [2:0] REG_POS_Y     = 3'd2;
   localparam logic [2:0] REG_SCALE_X   = 3'd3;
   localparam logic [2:0] REG_SCALE_Y   = 3'd4;
   localparam logic [2:0] REG_ROT_COS   = 3'd5;
   localparam logic [2:0] REG_ROT_SIN   = 3'd6;

   localparam logic [COUNT_WIDTH-1:0] MAX_RESULTS = 3'd6;

   // whole-unit offsets in Q15.8
   localparam int POINT_OFFSET  = 10 * 256;
   localparam int RIBBON_HEIGHT = 20 * 256;

   localparam int ROT_SHIFT   = 14;
   localparam int SCALE_SHIFT = 8;

   localparam logic signed [FACTOR_WIDTH-1:0] SCALE_RESET = 16'sd256;
   localparam logic signed [FACTOR_WIDTH-1:0] COS_RESET   = 16'sd16384;

   typedef struct packed {
      logic rot;
      logic run_end;
   } ppe_ctl_type;

endpackage

// File: src/ppe_front.sv
// Front end: accepts vertices, tracks the held vertex and expands each item
// into its raw primitive vertices, one per cycle unless the queue is full. Depends on ppe_pkg.
module ppe_front #(
   parameter int COORD_WIDTH = ppe_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [ppe_pkg::MODE_WIDTH-1:0]         draw_mode,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_WIDTH-1:0]          req_vert_x,
   input  logic signed [COORD_WIDTH-1:0]          req_vert_y,
   input  logic [ppe_pkg::COLOR_WIDTH-1:0]        req_vert_color,
   input  logic                                   req_list_first,
   input  logic                                   req_list_last,
   output logic                                   push,
   output logic signed [COORD_WIDTH:0]            push_x,
   output logic signed [COORD_WIDTH:0]            push_y,
   output logic [ppe_pkg::COLOR_WIDTH-1:0]        push_color,
   output ppe_pkg::ppe_ctl_type                   push_ctl,
   input  logic                                   q_full
);

   localparam int RAW_W = COORD_WIDTH + 1;
   localparam logic signed [RAW_W-1:0] OFS_PT = RAW_W'(ppe_pkg::POINT_OFFSET);
   localparam logic signed [RAW_W-1:0] OFS_RB = RAW_W'(ppe_pkg::RIBBON_HEIGHT);

   logic                                 busy_ff, busy_in;
   logic                                 have_prev_ff, have_prev_in;
   logic signed [COORD_WIDTH-1:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0]      prev_color_ff, prev_color_in;
   logic signed [COORD_WIDTH-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0]      cur_color_ff, cur_color_in;
   logic                                 cur_last_ff, cur_last_in;
   logic [ppe_pkg::MODE_WIDTH-1:0]       mode_ff, mode_in;
   logic [ppe_pkg::COUNT_WIDTH-1:0]      cnt_ff, cnt_in, idx_ff, idx_in;

   logic                                 accept, seg, dbl, end_once, run_end, done;
   logic [ppe_pkg::COUNT_WIDTH-1:0]      n_new;
   logic                                 sel_prev, y_zero;
   logic signed [RAW_W-1:0]              x_add, y_add;
   logic signed [COORD_WIDTH-1:0]        base_x, base_y;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   // result count of the incoming vertex under the current mode
   always_comb begin
      seg      = have_prev_ff && !req_list_first;
      dbl      = (req_list_first && req_list_last) || (seg && !req_list_last);
      end_once = !seg && req_list_last && !req_list_first;
      case (draw_mode)
         ppe_pkg::MODE_LINES: begin
            n_new = 3'd1 + {2'b00, dbl} + {2'b00, end_once};
         end
         ppe_pkg::MODE_FILL, ppe_pkg::MODE_SPECIAL: begin
            n_new = seg ? ppe_pkg::MAX_RESULTS : 3'd0;
         end
         ppe_pkg::MODE_POINTS: begin
            n_new = 3'd3;
         end
         default: begin
            n_new = 3'd1;
         end
      endcase
   end

   assign run_end = (idx_ff == (cnt_ff - 3'd1));
   assign push    = busy_ff && (idx_ff < cnt_ff) && !q_full;
   assign done    = busy_ff && ((cnt_ff == 3'd0) || (push && run_end));

   // pick the source vertex and offsets of emission idx_ff
   always_comb begin
      sel_prev = 1'b0;
      y_zero   = 1'b0;
      x_add    = '0;
      y_add    = '0;
      case (mode_ff)
         ppe_pkg::MODE_FILL: begin
            case (idx_ff)
               3'd0: sel_prev = 1'b1;
               3'd1: begin
                  sel_prev = 1'b1;
                  y_zero   = 1'b1;
               end
               3'd3: begin
                  sel_prev = 1'b1;
                  y_zero   = 1'b1;
               end
               3'd4: y_zero = 1'b1;
               default: sel_prev = 1'b0;
            endcase
         end
         ppe_pkg::MODE_POINTS: begin
            case (idx_ff)
               3'd0: begin
                  x_add = OFS_PT;
                  y_add = -OFS_PT;
               end
               3'd1: begin
                  x_add = -OFS_PT;
                  y_add = -OFS_PT;
               end
               default: y_add = OFS_PT;
            endcase
         end
         ppe_pkg::MODE_SPECIAL: begin
            case (idx_ff)
               3'd0: sel_prev = 1'b1;
               3'd2: begin
                  sel_prev = 1'b1;
                  y_add    = OFS_RB;
               end
               3'd4: begin
                  sel_prev = 1'b1;
                  y_add    = OFS_RB;
               end
               3'd5: y_add = OFS_RB;
               default: sel_prev = 1'b0;
            endcase
         end
         default: sel_prev = 1'b0;
      endcase
   end

   assign base_x     = sel_prev ? prev_x_ff : cur_x_ff;
   assign base_y     = sel_prev ? prev_y_ff : cur_y_ff;
   assign push_x     = RAW_W'(base_x) + x_add;
   assign push_y     = y_zero ? '0 : (RAW_W'(base_y) + y_add);
   assign push_color = sel_prev ? prev_color_ff : cur_color_ff;
   assign push_ctl   = '{rot: (mode_ff == ppe_pkg::MODE_SPECIAL), run_end: run_end};

   always_comb begin
      busy_in       = busy_ff;
      have_prev_in  = have_prev_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_color_in = prev_color_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_color_in  = cur_color_ff;
      cur_last_in   = cur_last_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      if (accept) begin
         busy_in      = 1'b1;
         cur_x_in     = req_vert_x;
         cur_y_in     = req_vert_y;
         cur_color_in = req_vert_color;
         cur_last_in  = req_list_last;
         mode_in      = draw_mode;
         cnt_in       = n_new;
         idx_in       = '0;
      end else begin
         if (push) begin
            idx_in = idx_ff + 3'd1;
         end
         // retire: the current vertex becomes the held one
         if (done) begin
            busy_in       = 1'b0;
            prev_x_in     = cur_x_ff;
            prev_y_in     = cur_y_ff;
            prev_color_in = cur_color_ff;
            have_prev_in  = !cur_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         have_prev_ff  <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_color_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         have_prev_ff  <= have_prev_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_color_ff <= prev_color_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      cur_color_ff <= cur_color_in;
      cur_last_ff  <= cur_last_in;
      mode_ff      <= mode_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= cnt_ff))
      else $error("emission index overran the result count");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= ppe_pkg::MAX_RESULTS))
      else $error("result count above six");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (idx_ff == 3'd0)))
      else $error("accepted item did not start at emission zero");

   a_last_retires: assert property (@(posedge clock) disable iff (reset)
      (push && push_ctl.run_end) |=> (!busy_ff && req_ready))
      else $error("front did not retire after the final emission");

endmodule

// File: src/ppe_queue.sv
// Short vertex queue between front and back end.
// Depends on ppe_pkg for its depth and control type.
module ppe_queue #(
   parameter int COORD_WIDTH = ppe_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [COORD_WIDTH:0]       push_x,
   input  logic signed [COORD_WIDTH:0]       push_y,
   input  logic [ppe_pkg::COLOR_WIDTH-1:0]   push_color,
   input  ppe_pkg::ppe_ctl_type              push_ctl,
   output logic                              full,
   input  logic                              pop,
   output logic                              empty,
   output logic signed [COORD_WIDTH:0]       head_x,
   output logic signed [COORD_WIDTH:0]       head_y,
   output logic [ppe_pkg::COLOR_WIDTH-1:0]   head_color,
   output ppe_pkg::ppe_ctl_type              head_ctl
);

   localparam int DEPTH = ppe_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [COORD_WIDTH:0]       entry_x_ff [DEPTH];
   logic signed [COORD_WIDTH:0]       entry_y_ff [DEPTH];
   logic [ppe_pkg::COLOR_WIDTH-1:0]   entry_color_ff [DEPTH];
   ppe_pkg::ppe_ctl_type              entry_ctl_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign head_x     = entry_x_ff[rd_ptr_ff];
   assign head_y     = entry_y_ff[rd_ptr_ff];
   assign head_color = entry_color_ff[rd_ptr_ff];
   assign head_ctl   = entry_ctl_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_x_ff[wr_ptr_ff]     <= push_x;
         entry_y_ff[wr_ptr_ff]     <= push_y;
         entry_color_ff[wr_ptr_ff] <= push_color;
         entry_ctl_ff[wr_ptr_ff]   <= push_ctl;
      end
   end

endmodule

// File: src/ppe_back.sv
// Back end: transform pipeline (rotate, scale, offset, saturate)
// feeding the result register. Depends on ppe_pkg.
module ppe_back #(
   parameter int COORD_WIDTH = ppe_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     q_empty,
   output logic                                     pop,
   input  logic signed [COORD_WIDTH:0]              head_x,
   input  logic signed [COORD_WIDTH:0]              head_y,
   input  logic [ppe_pkg::COLOR_WIDTH-1:0]          head_color,
   input  ppe_pkg::ppe_ctl_type                     head_ctl,
   input  logic signed [COORD_WIDTH-1:0]            pos_x,
   input  logic signed [COORD_WIDTH-1:0]            pos_y,
   input  logic signed [ppe_pkg::FACTOR_WIDTH-1:0]  scale_x,
   input  logic signed [ppe_pkg::FACTOR_WIDTH-1:0]  scale_y,
   input  logic signed [ppe_pkg::FACTOR_WIDTH-1:0]  rot_cos,
   input  logic signed [ppe_pkg::FACTOR_WIDTH-1:0]  rot_sin,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_y,
   output logic [ppe_pkg::COLOR_WIDTH-1:0]          rsp_out_color,
   output logic                                     rsp_run_end
);

   localparam int FW  = ppe_pkg::FACTOR_WIDTH;
   localparam int D_W = COORD_WIDTH + 2;
   localparam int P_W = D_W + FW;
   localparam int S_W = P_W + 1;
   localparam int R_W = S_W - ppe_pkg::ROT_SHIFT;
   localparam int M_W = R_W + FW;
   localparam int O_W = M_W - ppe_pkg::SCALE_SHIFT + 1;
   localparam logic signed [S_W-1:0] ROT_RND = S_W'(2 ** (ppe_pkg::ROT_SHIFT - 1));
   localparam logic signed [M_W-1:0] SC_RND  = M_W'(2 ** (ppe_pkg::SCALE_SHIFT - 1));
   localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic en;

   logic                            s0_valid_ff, s0_valid_in;
   logic signed [D_W-1:0]           s0_dx_ff, s0_dx_in, s0_dy_ff, s0_dy_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0] s0_color_ff;
   ppe_pkg::ppe_ctl_type            s0_ctl_ff;

   logic                            s1_valid_ff;
   logic signed [D_W-1:0]           s1_dx_ff, s1_dy_ff;
   logic signed [P_W-1:0]           s1_xc_ff, s1_xc_in, s1_ys_ff, s1_ys_in;
   logic signed [P_W-1:0]           s1_xs_ff, s1_xs_in, s1_yc_ff, s1_yc_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0] s1_color_ff;
   ppe_pkg::ppe_ctl_type            s1_ctl_ff;

   logic                            s2_valid_ff;
   logic signed [S_W-1:0]           sum_x, sum_y;
   logic signed [R_W-1:0]           s2_rx_ff, s2_rx_in, s2_ry_ff, s2_ry_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0] s2_color_ff;
   logic                            s2_end_ff;

   logic                            s3_valid_ff;
   logic signed [M_W-1:0]           s3_mx_ff, s3_mx_in, s3_my_ff, s3_my_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0] s3_color_ff;
   logic                            s3_end_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [O_W-1:0]           off_x, off_y;
   logic signed [COORD_WIDTH-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [ppe_pkg::COLOR_WIDTH-1:0] rsp_color_ff;
   logic                            rsp_end_ff;

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [O_W-1:0] v);
      logic signed [COORD_WIDTH-1:0] r;
      if (v > O_W'(CMAX)) begin
         r = CMAX;
      end else if (v < O_W'(CMIN)) begin
         r = CMIN;
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // the whole pipe advances unless the result register is held
   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && !q_empty;

   always_comb begin
      s0_valid_in = !q_empty;
      s0_dx_in    = head_ctl.rot ? (D_W'(head_x) - D_W'(pos_x)) : D_W'(head_x);
      s0_dy_in    = head_ctl.rot ? (D_W'(head_y) - D_W'(pos_y)) : D_W'(head_y);

      s1_xc_in = P_W'(s0_dx_ff) * P_W'(rot_cos);
      s1_ys_in = P_W'(s0_dy_ff) * P_W'(rot_sin);
      s1_xs_in = P_W'(s0_dx_ff) * P_W'(rot_sin);
      s1_yc_in = P_W'(s0_dy_ff) * P_W'(rot_cos);

      sum_x    = S_W'(s1_xc_ff) - S_W'(s1_ys_ff) + ROT_RND;
      sum_y    = S_W'(s1_xs_ff) + S_W'(s1_yc_ff) + ROT_RND;
      s2_rx_in = s1_ctl_ff.rot ? R_W'(sum_x >>> ppe_pkg::ROT_SHIFT) : R_W'(s1_dx_ff);
      s2_ry_in = s1_ctl_ff.rot ? R_W'(sum_y >>> ppe_pkg::ROT_SHIFT) : R_W'(s1_dy_ff);

      s3_mx_in = M_W'(s2_rx_ff) * M_W'(scale_x);
      s3_my_in = M_W'(s2_ry_ff) * M_W'(scale_y);

      off_x        = O_W'((s3_mx_ff + SC_RND) >>> ppe_pkg::SCALE_SHIFT) + O_W'(pos_x);
      off_y        = O_W'((s3_my_ff + SC_RND) >>> ppe_pkg::SCALE_SHIFT) + O_W'(pos_y);
      rsp_x_in     = sat(off_x);
      rsp_y_in     = sat(off_y);
      rsp_valid_in = s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_dx_ff     <= s0_dx_in;
         s0_dy_ff     <= s0_dy_in;
         s0_color_ff  <= head_color;
         s0_ctl_ff    <= head_ctl;
         s1_dx_ff     <= s0_dx_ff;
         s1_dy_ff     <= s0_dy_ff;
         s1_xc_ff     <= s1_xc_in;
         s1_ys_ff     <= s1_ys_in;
         s1_xs_ff     <= s1_xs_in;
         s1_yc_ff     <= s1_yc_in;
         s1_color_ff  <= s0_color_ff;
         s1_ctl_ff    <= s0_ctl_ff;
         s2_rx_ff     <= s2_rx_in;
         s2_ry_ff     <= s2_ry_in;
         s2_color_ff  <= s1_color_ff;
         s2_end_ff    <= s1_ctl_ff.run_end;
         s3_mx_ff     <= s3_mx_in;
         s3_my_ff     <= s3_my_in;
         s3_color_ff  <= s2_color_ff;
         s3_end_ff    <= s2_end_ff;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_color_ff <= s3_color_ff;
         rsp_end_ff   <= s3_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_color = rsp_color_ff;
   assign rsp_run_end   = rsp_end_ff;

endmodule

// File: src/polyline_primitive_expander.sv
// Top level of the polyline primitive expander: register file and the
// front end, queue and back end. Depends on ppe_pkg and all ppe_* modules.
//
// Usage:
//  - req_* carries one colored vertex per item with list_first/list_last
//    marks; rsp_* carries the emitted primitive vertices, run_end set on
//    the final vertex an item causes. Both channels are valid/ready.
//  - csr_* is an APB-style port, registers at byte address 4*index:
//    draw_mode, pos_x, pos_y, scale_x, scale_y, rot_cos, rot_sin.
//    pready is tied high; write only while the block is idle.
//  - The front end expands one item at a time, one emitted vertex per cycle
//    unless the queue is full, and takes the next item only after the current
//    one retires. An item's result count runs from 0 to 6.
//  - Path: an item's results pass through the queue and then the transform
//    pipeline into the result register.
//  - A stalled receiver holds the result register, which freezes the
//    pipeline; the queue then fills and the front end stops accepting.
//  - Reset restores the register defaults (unit scale, zero rotation) and
//    drops any held vertex; items in flight are lost.
module polyline_primitive_expander #(
   parameter int COORD_WIDTH = ppe_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_vert_x,
   input  logic signed [COORD_WIDTH-1:0]         req_vert_y,
   input  logic [ppe_pkg::COLOR_WIDTH-1:0]       req_vert_color,
   input  logic                                  req_list_first,
   input  logic                                  req_list_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_y,
   output logic [ppe_pkg::COLOR_WIDTH-1:0]       rsp_out_color,
   output logic                                  rsp_run_end,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ppe_pkg::ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [ppe_pkg::DATA_WIDTH-1:0]        csr_pwdata,
   output logic [ppe_pkg::DATA_WIDTH-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int FW = ppe_pkg::FACTOR_WIDTH;
   localparam int DW = ppe_pkg::DATA_WIDTH;

   // configuration registers
   logic [ppe_pkg::MODE_WIDTH-1:0] draw_mode_ff, draw_mode_in;
   logic signed [COORD_WIDTH-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [FW-1:0]           scale_x_ff, scale_x_in, scale_y_ff, scale_y_in;
   logic signed [FW-1:0]           rot_cos_ff, rot_cos_in, rot_sin_ff, rot_sin_in;

   logic       csr_write;
   logic [2:0] csr_index;

   // front to queue
   logic                            push, q_full;
   logic signed [COORD_WIDTH:0]     push_x, push_y;
   logic [ppe_pkg::COLOR_WIDTH-1:0] push_color;
   ppe_pkg::ppe_ctl_type            push_ctl;

   // queue to back
   logic                            pop, q_empty;
   logic signed [COORD_WIDTH:0]     head_x, head_y;
   logic [ppe_pkg::COLOR_WIDTH-1:0] head_color;
   ppe_pkg::ppe_ctl_type            head_ctl;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   // register write decode; the unused index is dropped
   always_comb begin
      draw_mode_in = draw_mode_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      scale_x_in   = scale_x_ff;
      scale_y_in   = scale_y_ff;
      rot_cos_in   = rot_cos_ff;
      rot_sin_in   = rot_sin_ff;
      if (csr_write) begin
         case (csr_index)
            ppe_pkg::REG_DRAW_MODE: draw_mode_in = csr_pwdata[ppe_pkg::MODE_WIDTH-1:0];
            ppe_pkg::REG_POS_X:     pos_x_in     = csr_pwdata[COORD_WIDTH-1:0];
            ppe_pkg::REG_POS_Y:     pos_y_in     = csr_pwdata[COORD_WIDTH-1:0];
            ppe_pkg::REG_SCALE_X:   scale_x_in   = csr_pwdata[FW-1:0];
            ppe_pkg::REG_SCALE_Y:   scale_y_in   = csr_pwdata[FW-1:0];
            ppe_pkg::REG_ROT_COS:   rot_cos_in   = csr_pwdata[FW-1:0];
            ppe_pkg::REG_ROT_SIN:   rot_sin_in   = csr_pwdata[FW-1:0];
            default:                draw_mode_in = draw_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff <= ppe_pkg::MODE_LINES;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         scale_x_ff   <= ppe_pkg::SCALE_RESET;
         scale_y_ff   <= ppe_pkg::SCALE_RESET;
         rot_cos_ff   <= ppe_pkg::COS_RESET;
         rot_sin_ff   <= '0;
      end else begin
         draw_mode_ff <= draw_mode_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         scale_x_ff   <= scale_x_in;
         scale_y_ff   <= scale_y_in;
         rot_cos_ff   <= rot_cos_in;
         rot_sin_ff   <= rot_sin_in;
      end
   end

   // read back, signed registers sign-extended
   always_comb begin
      case (csr_index)
         ppe_pkg::REG_DRAW_MODE: csr_prdata = DW'(draw_mode_ff);
         ppe_pkg::REG_POS_X:     csr_prdata = DW'(pos_x_ff);
         ppe_pkg::REG_POS_Y:     csr_prdata = DW'(pos_y_ff);
         ppe_pkg::REG_SCALE_X:   csr_prdata = DW'(scale_x_ff);
         ppe_pkg::REG_SCALE_Y:   csr_prdata = DW'(scale_y_ff);
         ppe_pkg::REG_ROT_COS:   csr_prdata = DW'(rot_cos_ff);
         ppe_pkg::REG_ROT_SIN:   csr_prdata = DW'(rot_sin_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // classify and expand, one emitted vertex per cycle unless the queue is full
   ppe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .draw_mode      (draw_mode_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vert_x     (req_vert_x),
      .req_vert_y     (req_vert_y),
      .req_vert_color (req_vert_color),
      .req_list_first (req_list_first),
      .req_list_last  (req_list_last),
      .push           (push),
      .push_x         (push_x),
      .push_y         (push_y),
      .push_color     (push_color),
      .push_ctl       (push_ctl),
      .q_full         (q_full)
   );

   // decouple expansion from the transform pipeline
   ppe_queue #(.COORD_WIDTH(COORD_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_x     (push_x),
      .push_y     (push_y),
      .push_color (push_color),
      .push_ctl   (push_ctl),
      .full       (q_full),
      .pop        (pop),
      .empty      (q_empty),
      .head_x     (head_x),
      .head_y     (head_y),
      .head_color (head_color),
      .head_ctl   (head_ctl)
   );

   // rotate, scale, offset and saturate
   ppe_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .pop           (pop),
      .head_x        (head_x),
      .head_y        (head_y),
      .head_color    (head_color),
      .head_ctl      (head_ctl),
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .scale_x       (scale_x_ff),
      .scale_y       (scale_y_ff),
      .rot_cos       (rot_cos_ff),
      .rot_sin       (rot_sin_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_color (rsp_out_color),
      .rsp_run_end   (rsp_run_end)
   );

endmodule

// File: dv/tb_top.sv
// Self-checking bench for polyline_primitive_expander: table-driven directed items,
// then random vertex lists under changing register settings, all checked in order.
// Depends on ppe_pkg and the polyline_primitive_expander RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = ppe_pkg::COORD_WIDTH_DEFAULT;

   // Modes above special all pass the vertex through; pick one in range and one at the top.
   localparam logic [ppe_pkg::MODE_WIDTH-1:0] MODE_PASS  = 3'd4;
   localparam logic [ppe_pkg::MODE_WIDTH-1:0] MODE_SPARE = 3'd7;
   // Register index past the end of the register list; writes there are dropped.
   localparam logic [2:0] REG_UNUSED = 3'd7;

   localparam int STIM_ROWS      = 37;
   localparam int DIRECTED_ITEMS = 23;
   localparam int RANDOM_ITEMS   = 297;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
   localparam int PHASE_ITEMS    = 30;
   // Queue plus transform pipeline plus one full front-end expansion, with margin.
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_SHOWN      = 10;
   localparam int PRED           = -1;

   // ---------------------------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------------------------
   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [CW-1:0]                req_vert_x = '0;
   logic signed [CW-1:0]                req_vert_y = '0;
   logic [ppe_pkg::COLOR_WIDTH-1:0]     req_vert_color = '0;
   logic                                req_list_first = 1'b0;
   logic                                req_list_last = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [CW-1:0]                rsp_out_x;
   logic signed [CW-1:0]                rsp_out_y;
   logic [ppe_pkg::COLOR_WIDTH-1:0]     rsp_out_color;
   logic                                rsp_run_end;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [ppe_pkg::ADDR_WIDTH-1:0]      csr_paddr = '0;
   logic [ppe_pkg::DATA_WIDTH-1:0]      csr_pwdata = '0;
   logic [ppe_pkg::DATA_WIDTH-1:0]      csr_prdata;
   logic                                csr_pready;

   polyline_primitive_expander #(.COORD_WIDTH(CW)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vert_x     (req_vert_x),
      .req_vert_y     (req_vert_y),
      .req_vert_color (req_vert_color),
      .req_list_first (req_list_first),
      .req_list_last  (req_list_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_color  (rsp_out_color),
      .rsp_run_end    (rsp_run_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops results.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Expander prediction: local copy of the registers and the held vertex
   // ---------------------------------------------------------------------------------------
   typedef struct packed {
      logic signed [CW-1:0]            x;
      logic signed [CW-1:0]            y;
      logic [ppe_pkg::COLOR_WIDTH-1:0] color;
      logic                            run_end;
   } vertex_type;

   logic [ppe_pkg::MODE_WIDTH-1:0]  cfg_mode;
   longint                          cfg_pos_x, cfg_pos_y, cfg_scale_x, cfg_scale_y;
   longint                          cfg_cos, cfg_sin;
   longint                          held_x, held_y;
   logic [ppe_pkg::COLOR_WIDTH-1:0] held_color;
   logic                            held_valid;

   vertex_type burst_q[$];      // vertices caused by the item being predicted
   vertex_type emitted_q[$];    // vertices still owed by the block, oldest first

   int items_sent = 0;
   int fail_count = 0;
   int send_idle  = 18;
   int recv_idle  = 49;

   function automatic logic signed [CW-1:0] clamp_coord(input longint v);
      longint     hi;
      longint     lo;
      logic [63:0] bits;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      else if (v < lo) v = lo;
      bits = v;
      return bits[CW-1:0];
   endfunction

   // Rotate about the position in special mode, then scale about the origin and offset.
   function automatic void place_vertex(input longint px, input longint py,
                                        input logic [ppe_pkg::COLOR_WIDTH-1:0] c);
      longint     rx, ry, dx, dy;
      vertex_type v;
      rx = px;
      ry = py;
      if (cfg_mode == ppe_pkg::MODE_SPECIAL) begin
         dx = px - cfg_pos_x;
         dy = py - cfg_pos_y;
         rx = (dx * cfg_cos - dy * cfg_sin + (longint'(1) <<< (ppe_pkg::ROT_SHIFT - 1)))
              >>> ppe_pkg::ROT_SHIFT;
         ry = (dx * cfg_sin + dy * cfg_cos + (longint'(1) <<< (ppe_pkg::ROT_SHIFT - 1)))
              >>> ppe_pkg::ROT_SHIFT;
      end
      v.x = clamp_coord(((rx * cfg_scale_x + (longint'(1) <<< (ppe_pkg::SCALE_SHIFT - 1)))
                         >>> ppe_pkg::SCALE_SHIFT) + cfg_pos_x);
      v.y = clamp_coord(((ry * cfg_scale_y + (longint'(1) <<< (ppe_pkg::SCALE_SHIFT - 1)))
                         >>> ppe_pkg::SCALE_SHIFT) + cfg_pos_y);
      v.color = c;
      v.run_end = 1'b0;
      burst_q.insert(burst_q.size(), v);
   endfunction

   function automatic void expand_vertex(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input logic [ppe_pkg::COLOR_WIDTH-1:0] c,
                                         input logic opens, input logic closes);
      longint vx, vy;
      logic   seg;
      vx = x;
      vy = y;
      // A vertex joins a segment only when one is held and it does not open a new list.
      seg = held_valid && !opens;
      burst_q.delete();
      case (cfg_mode)
         ppe_pkg::MODE_LINES: begin
            place_vertex(vx, vy, c);
            if ((opens && closes) || (seg && !closes)) place_vertex(vx, vy, c);
            if (!seg && closes && !opens) place_vertex(vx, vy, c);
         end
         ppe_pkg::MODE_FILL: if (seg) begin
            place_vertex(held_x, held_y, held_color);
            place_vertex(held_x, 0, held_color);
            place_vertex(vx, vy, c);
            place_vertex(held_x, 0, held_color);
            place_vertex(vx, 0, c);
            place_vertex(vx, vy, c);
         end
         ppe_pkg::MODE_POINTS: begin
            place_vertex(vx + ppe_pkg::POINT_OFFSET, vy - ppe_pkg::POINT_OFFSET, c);
            place_vertex(vx - ppe_pkg::POINT_OFFSET, vy - ppe_pkg::POINT_OFFSET, c);
            place_vertex(vx, vy + ppe_pkg::POINT_OFFSET, c);
         end
         ppe_pkg::MODE_SPECIAL: if (seg) begin
            place_vertex(held_x, held_y, held_color);
            place_vertex(vx, vy, c);
            place_vertex(held_x, held_y + ppe_pkg::RIBBON_HEIGHT, held_color);
            place_vertex(vx, vy, c);
            place_vertex(held_x, held_y + ppe_pkg::RIBBON_HEIGHT, held_color);
            place_vertex(vx, vy + ppe_pkg::RIBBON_HEIGHT, c);
         end
         default: place_vertex(vx, vy, c);
      endcase
      // Every mode tracks the list the same way.
      held_x = vx;
      held_y = vy;
      held_color = c;
      held_valid = !closes;
   endfunction

   // Move the burst into the owed queue, run_end on its final vertex.
   function automatic void commit_burst();
      vertex_type v;
      for (int i = 0; i < burst_q.size(); i++) begin
         v = burst_q[i];
         v.run_end = (i == burst_q.size() - 1);
         emitted_q.insert(emitted_q.size(), v);
      end
   endfunction

   function automatic void apply_setting(input logic [2:0] idx,
                                         input logic [ppe_pkg::DATA_WIDTH-1:0] value);
      logic signed [CW-1:0]                    c;
      logic signed [ppe_pkg::FACTOR_WIDTH-1:0] f;
      c = value[CW-1:0];
      f = value[ppe_pkg::FACTOR_WIDTH-1:0];
      case (idx)
         ppe_pkg::REG_DRAW_MODE: cfg_mode = value[ppe_pkg::MODE_WIDTH-1:0];
         ppe_pkg::REG_POS_X:     cfg_pos_x = c;
         ppe_pkg::REG_POS_Y:     cfg_pos_y = c;
         ppe_pkg::REG_SCALE_X:   cfg_scale_x = f;
         ppe_pkg::REG_SCALE_Y:   cfg_scale_y = f;
         ppe_pkg::REG_ROT_COS:   cfg_cos = f;
         ppe_pkg::REG_ROT_SIN:   cfg_sin = f;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers; every task starts and ends on a rising edge
   // ---------------------------------------------------------------------------------------
   // Setup phase, access phase, then a quiet phase so back-to-back writes never
   // assign the same select twice in one step.
   task automatic csr_write(input logic [2:0] idx,
                            input logic [ppe_pkg::DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_setting(idx, value);
      @(posedge clock);
   endtask

   // Hold off the sender until every owed vertex is out and the front end has gone quiet;
   // items with no vertex may still be in flight when the queue empties.
   task automatic await_idle();
      req_valid <= 1'b0;
      while (emitted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offer one vertex, hold it until accepted, then predict. A known count replaces the
   // prediction with copies of the input vertex.
   task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic [ppe_pkg::COLOR_WIDTH-1:0] c,
                              input logic opens, input logic closes, input int known_n);
      vertex_type v;
      if (items_sent < TOTAL_ITEMS / 3) begin
         send_idle = 18;
         recv_idle = 49;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle = 49;
         recv_idle = 18;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_vert_x     <= x;
      req_vert_y     <= y;
      req_vert_color <= c;
      req_list_first <= opens;
      req_list_last  <= closes;
      do @(posedge clock); while (!req_ready);
      expand_vertex(x, y, c, opens, closes);
      if (known_n >= 0) begin
         burst_q.delete();
         v.x = x;
         v.y = y;
         v.color = c;
         v.run_end = 1'b0;
         repeat (known_n) burst_q.insert(burst_q.size(), v);
      end
      commit_burst();
      items_sent++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Random value sources: moderate, fully random and extreme values, the extremes on purpose
   // ---------------------------------------------------------------------------------------
   function automatic logic [CW-1:0] rand_coord();
      logic [31:0] t;
      case ($urandom_range(5))
         0: t = {1'b0, {31{1'b1}}} >> (32 - CW);
         1: t = 32'(1) << (CW - 1);
         2, 3: t = $urandom;
         default: t = 32'($urandom_range(32767)) - 32'd16384;
      endcase
      return t[CW-1:0];
   endfunction

   function automatic logic [ppe_pkg::DATA_WIDTH-1:0] rand_scale();
      logic [15:0] f;
      case ($urandom_range(5))
         0: f = 16'h8000;
         1: f = 16'h7FFF;
         2: f = 16'($urandom);
         default: f = 16'($urandom_range(1023)) - 16'd512;
      endcase
      return {{16{f[15]}}, f};
   endfunction

   function automatic logic [ppe_pkg::DATA_WIDTH-1:0] rand_trig();
      logic [15:0] f;
      case ($urandom_range(5))
         0: f = 16'hC000;
         1: f = 16'h4000;
         2: f = 16'h0000;
         default: f = 16'($urandom_range(32768)) - 16'd16384;
      endcase
      return {{16{f[15]}}, f};
   endfunction

   // One random setting, then well-formed lists of random content with some broken marks.
   task automatic random_phase(input int phase);
      logic [CW-1:0]                  c;
      logic [ppe_pkg::MODE_WIDTH-1:0] mode;
      int                             target;
      int                             len;
      logic                           noisy;
      logic                           opens;
      logic                           closes;
      await_idle();
      // Cycle through the four shapes, sometimes land on a pass-through code.
      if ($urandom_range(9) < 8) mode = ppe_pkg::MODE_WIDTH'(phase % 4);
      else mode = ppe_pkg::MODE_WIDTH'($urandom_range(4, 7));
      csr_write(ppe_pkg::REG_DRAW_MODE, 32'(mode));
      c = rand_coord();
      csr_write(ppe_pkg::REG_POS_X, {{(ppe_pkg::DATA_WIDTH - CW){c[CW-1]}}, c});
      c = rand_coord();
      csr_write(ppe_pkg::REG_POS_Y, {{(ppe_pkg::DATA_WIDTH - CW){c[CW-1]}}, c});
      csr_write(ppe_pkg::REG_SCALE_X, rand_scale());
      csr_write(ppe_pkg::REG_SCALE_Y, rand_scale());
      csr_write(ppe_pkg::REG_ROT_COS, rand_trig());
      csr_write(ppe_pkg::REG_ROT_SIN, rand_trig());
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target && items_sent < TOTAL_ITEMS) begin
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            noisy = ($urandom_range(99) < 15);
            opens = noisy ? 1'($urandom_range(1)) : (k == 0);
            closes = noisy ? 1'($urandom_range(1)) : (k == len - 1);
            send_vertex(rand_coord(), rand_coord(), $urandom, opens, closes, PRED);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------------------
   typedef struct packed {
      logic                            is_cfg;
      logic [2:0]                      reg_idx;
      logic [ppe_pkg::DATA_WIDTH-1:0]  reg_val;
      logic [CW-1:0]                   x;
      logic [CW-1:0]                   y;
      logic [ppe_pkg::COLOR_WIDTH-1:0] color;
      logic                            opens;
      logic                            closes;
      int                              known_n;
   } stim_row_type;

   function automatic stim_row_type item_row(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                             input logic [ppe_pkg::COLOR_WIDTH-1:0] c,
                                             input logic opens, input logic closes,
                                             input int n);
      stim_row_type r;
      r = '0;
      r.x = x;
      r.y = y;
      r.color = c;
      r.opens = opens;
      r.closes = closes;
      r.known_n = n;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(input logic [2:0] idx,
                                            input logic [ppe_pkg::DATA_WIDTH-1:0] v);
      stim_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.reg_idx = idx;
      r.reg_val = v;
      r.known_n = PRED;
      return r;
   endfunction

   stim_row_type stim_tbl [STIM_ROWS];

   // ---------------------------------------------------------------------------------------
   // Result checker: compare each accepted vertex with the oldest owed one
   // ---------------------------------------------------------------------------------------
   task automatic check_vertex();
      vertex_type want;
      if (emitted_q.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_SHOWN)
            $display("%0t: unexpected vertex x=%0d y=%0d color=%h end=%b", $realtime,
                     rsp_out_x, rsp_out_y, rsp_out_color, rsp_run_end);
      end else begin
         want = emitted_q.pop_front();
         if (rsp_out_x !== want.x || rsp_out_y !== want.y ||
             rsp_out_color !== want.color || rsp_run_end !== want.run_end) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t: vertex mismatch exp x=%0d y=%0d color=%h end=%b,",
                        $realtime, want.x, want.y, want.color, want.run_end,
                        " got x=%0d y=%0d color=%h end=%b",
                        rsp_out_x, rsp_out_y, rsp_out_color, rsp_run_end);
         end
      end
   endtask

   // Sample at the edge (pre-update values), then pick the next ready.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_vertex();
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int phase;
      // Lines mode at reset values is the identity, so those counts read straight off.
      stim_tbl = '{
         item_row(24'h000000, 24'h000000, 32'h00000000, 1'b1, 1'b1, 2),  // single vertex
         item_row(24'h7FFFFF, 24'h800000, 32'hFFFFFFFF, 1'b1, 1'b0, 1),  // list opens
         item_row(24'h800000, 24'h7FFFFF, 32'hA5A5A5A5, 1'b0, 1'b0, 2),  // inner vertex
         item_row(24'h000123, 24'hFFFE38, 32'h5A5A5A5A, 1'b0, 1'b1, 1),  // list closes
         item_row(24'h001000, 24'h002000, 32'h01234567, 1'b0, 1'b0, 1),  // no first mark
         item_row(24'hFFFFFF, 24'hFFFFFF, 32'h89ABCDEF, 1'b1, 1'b0, 1),  // reopen mid-list
         item_row(24'h00012C, 24'hFFFED4, 32'h13579BDF, 1'b0, 1'b1, 1),
         item_row(24'h00004D, 24'h000058, 32'h2468ACE0, 1'b0, 1'b1, 2),  // lone closing vertex
         item_row(24'h000005, 24'h000006, 32'h0F0F0F0F, 1'b1, 1'b0, 1),  // held across mode
         cfg_row(ppe_pkg::REG_DRAW_MODE, 32'(ppe_pkg::MODE_FILL)),
         item_row(24'h001000, 24'h002000, 32'hF0F0F0F0, 1'b0, 1'b0, PRED),
         item_row(24'hFFC000, 24'h7FFFFF, 32'h11223344, 1'b0, 1'b1, PRED),
         item_row(24'h000400, 24'h000800, 32'h55667788, 1'b1, 1'b0, 0),
         item_row(24'h000900, 24'h000A00, 32'h99AABBCC, 1'b1, 1'b1, 0),
         cfg_row(ppe_pkg::REG_DRAW_MODE, 32'(ppe_pkg::MODE_POINTS)),
         item_row(24'h7FFFFF, 24'h800000, 32'hDEADBEEF, 1'b1, 1'b1, PRED),
         item_row(24'h000000, 24'h000000, 32'hCAFEF00D, 1'b0, 1'b0, PRED),
         cfg_row(ppe_pkg::REG_POS_X, 32'h00001200),
         cfg_row(ppe_pkg::REG_POS_Y, 32'hFFFFF800),
         cfg_row(ppe_pkg::REG_SCALE_X, 32'hFFFF8000),
         cfg_row(ppe_pkg::REG_SCALE_Y, 32'h00007FFF),
         item_row(24'h000300, 24'hFFFD00, 32'h0BADF00D, 1'b1, 1'b1, PRED),
         cfg_row(ppe_pkg::REG_DRAW_MODE, 32'(ppe_pkg::MODE_SPECIAL)),
         cfg_row(ppe_pkg::REG_ROT_COS, 32'h00000000),
         cfg_row(ppe_pkg::REG_ROT_SIN, 32'h00004000),
         item_row(24'h000800, 24'h000400, 32'h10203040, 1'b1, 1'b0, 0),
         item_row(24'hFFF000, 24'h001400, 32'h50607080, 1'b0, 1'b0, PRED),
         item_row(24'h7FFFFF, 24'h800000, 32'h90A0B0C0, 1'b0, 1'b1, PRED),
         cfg_row(ppe_pkg::REG_ROT_COS, 32'hFFFFC000),
         cfg_row(ppe_pkg::REG_ROT_SIN, 32'hFFFFC000),
         item_row(24'h000100, 24'hFFFF00, 32'hD0E0F000, 1'b1, 1'b0, 0),
         item_row(24'h800000, 24'h7FFFFF, 32'h0A0B0C0D, 1'b0, 1'b1, PRED),
         cfg_row(ppe_pkg::REG_DRAW_MODE, 32'(MODE_PASS)),
         cfg_row(REG_UNUSED, 32'hFFFFFFFF),                               // must be dropped
         item_row(24'h000700, 24'hFFF900, 32'h76543210, 1'b1, 1'b1, PRED),
         cfg_row(ppe_pkg::REG_DRAW_MODE, 32'(MODE_SPARE)),
         item_row(24'h7FFFFF, 24'h7FFFFF, 32'hFEDCBA98, 1'b0, 1'b0, PRED)
      };

      // Match the block's reset state.
      cfg_mode    = ppe_pkg::MODE_LINES;
      cfg_pos_x   = 0;
      cfg_pos_y   = 0;
      cfg_scale_x = ppe_pkg::SCALE_RESET;
      cfg_scale_y = ppe_pkg::SCALE_RESET;
      cfg_cos     = ppe_pkg::COS_RESET;
      cfg_sin     = 0;
      held_x      = 0;
      held_y      = 0;
      held_color  = '0;
      held_valid  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table; register writes only once the block has drained.
      for (int r = 0; r < STIM_ROWS; r++) begin
         if (stim_tbl[r].is_cfg) begin
            await_idle();
            csr_write(stim_tbl[r].reg_idx, stim_tbl[r].reg_val);
         end else begin
            send_vertex(stim_tbl[r].x, stim_tbl[r].y, stim_tbl[r].color,
                        stim_tbl[r].opens, stim_tbl[r].closes, stim_tbl[r].known_n);
         end
      end

      for (phase = 0; items_sent < TOTAL_ITEMS; phase++) random_phase(phase);

      // Drop valid, wait out every owed vertex, then watch for strays.
      req_valid <= 1'b0;
      while (emitted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
